/* design/char_lcd_nibble_interface_top_assert.svh */
// ----------------------------------------------------------------------------
// Character LCD nibble interface - assertion macros
// Same-cycle and next-cycle implication property wrappers on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_INTERFACE_TOP_ASSERT_SVH
`define CHAR_LCD_NIBBLE_INTERFACE_TOP_ASSERT_SVH

// same-cycle implication
`define CLNI_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CLNI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/clni_pkg.sv */
// ----------------------------------------------------------------------------
// clni_pkg
// Types, codes and constants shared by the LCD nibble interface modules.
// ----------------------------------------------------------------------------
`default_nettype none

package clni_pkg;

    localparam int WAIT_BITS = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [31:0] WAIT_MAX32 = 32'((64'd1 << WAIT_BITS) - 64'd1);

    typedef logic [WAIT_BITS-1:0] wait_t;

    localparam wait_t WAIT_MAX = wait_t'(WAIT_MAX32);

    typedef enum logic [2:0] {
        MODE_TICK  = 3'd0,
        MODE_CMD   = 3'd1,
        MODE_CHAR  = 3'd2,
        MODE_GOTO  = 3'd3,
        MODE_CLEAR = 3'd4
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POWER_ON    = 3'd0,
        CFG_LONG_INIT   = 3'd1,
        CFG_SHORT_INIT  = 3'd2,
        CFG_BYTE_SETTLE = 3'd3,
        CFG_CLEAR       = 3'd4,
        CFG_STROBE      = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [23:0] power_on_wait;
        logic [23:0] long_init_wait;
        logic [23:0] short_init_wait;
        logic [15:0] byte_settle_wait;
        logic [23:0] clear_wait;
        logic [7:0]  strobe_ticks;
    } cfg_t;

    localparam logic [23:0] RST_POWER_ON    = 24'd15000;
    localparam logic [23:0] RST_LONG_INIT   = 24'd5000;
    localparam logic [23:0] RST_SHORT_INIT  = 24'd100;
    localparam logic [15:0] RST_BYTE_SETTLE = 16'd40;
    localparam logic [23:0] RST_CLEAR       = 24'd2000;
    localparam logic [7:0]  RST_STROBE      = 8'd1;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'd0,
        ST_POWER    = 5'd1,
        ST_I_STB1   = 5'd2,
        ST_I_WAIT1  = 5'd3,
        ST_I_STB2   = 5'd4,
        ST_I_WAIT2  = 5'd5,
        ST_I_STB3   = 5'd6,
        ST_I_WAIT3  = 5'd7,
        ST_I_STB4   = 5'd8,
        ST_I_WAIT4  = 5'd9,
        ST_U_STROBE = 5'd10,
        ST_U_GAP    = 5'd11,
        ST_U_SETTLE = 5'd12,
        ST_U_EXTRA  = 5'd13,
        ST_B_STROBE = 5'd14,
        ST_B_GAP    = 5'd15,
        ST_B_SETTLE = 5'd16,
        ST_B_EXTRA  = 5'd17
    } step_t;

    localparam logic [7:0] BYTE_FUNC_SET = 8'h28;
    localparam logic [7:0] BYTE_DISP_ON  = 8'h0C;
    localparam logic [7:0] BYTE_ENTRY    = 8'h06;
    localparam logic [7:0] BYTE_CLEAR    = 8'h01;
    localparam logic [7:0] BYTE_GOTO     = 8'h80;
    localparam logic [3:0] NIB_INIT      = 4'h3;
    localparam logic [3:0] NIB_4BIT      = 4'h2;

    typedef struct packed {
        logic       reg_select;
        logic       read_write;
        logic [3:0] data_nibble;
        logic       enable;
        logic       busy_res;
        logic       rejected;
    } result_t;

    // zero counts as one tick, oversize saturates to the counter range
    function automatic wait_t clip(input logic [CFG_W-1:0] t);
        logic [31:0] t32;
        t32 = 32'(t);
        if (t32 == 32'd0)
        begin
            return wait_t'(1);
        end
        else if (t32 > WAIT_MAX32)
        begin
            return WAIT_MAX;
        end
        return wait_t'(t32);
    endfunction

endpackage

`default_nettype wire

/* design/clni_cfg.sv */
// ----------------------------------------------------------------------------
// clni_cfg
// Timing register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module clni_cfg
    import clni_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_on_wait    <= RST_POWER_ON;
            cfg_reg.long_init_wait   <= RST_LONG_INIT;
            cfg_reg.short_init_wait  <= RST_SHORT_INIT;
            cfg_reg.byte_settle_wait <= RST_BYTE_SETTLE;
            cfg_reg.clear_wait       <= RST_CLEAR;
            cfg_reg.strobe_ticks     <= RST_STROBE;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_POWER_ON:    cfg_reg.power_on_wait    <= cfg_data[23:0];
                CFG_LONG_INIT:   cfg_reg.long_init_wait   <= cfg_data[23:0];
                CFG_SHORT_INIT:  cfg_reg.short_init_wait  <= cfg_data[23:0];
                CFG_BYTE_SETTLE: cfg_reg.byte_settle_wait <= cfg_data[15:0];
                CFG_CLEAR:       cfg_reg.clear_wait       <= cfg_data[23:0];
                CFG_STROBE:      cfg_reg.strobe_ticks     <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* design/clni_seq.sv */
// ----------------------------------------------------------------------------
// clni_seq
// Pin sequencer: request decode, pin levels and step/tick advance per tick.
// ----------------------------------------------------------------------------
`default_nettype none

module clni_seq
    import clni_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [2:0] mode,
    input  wire logic [7:0] value,
    input  cfg_t            cfg,
    output result_t         result
);

    step_t            step_reg,      step_next;
    wait_t            wait_reg,      wait_next;
    logic [7:0]       held_reg,      held_next;
    logic             low_nibble_reg, low_nibble_next;
    logic [CFG_W-1:0] pend_reg,      pend_next;
    logic             sel_reg,       sel_next;
    logic [3:0]       nib_reg,       nib_next;
    logic             en_reg,        en_next;

    // state after the request of this tick
    step_t            req_step;
    wait_t            req_wait;
    logic [7:0]       req_held;
    logic             req_low;
    logic [CFG_W-1:0] req_pend;
    logic             req_sel;
    logic [3:0]       req_nib;
    logic             req_en;
    logic             req_rej;

    logic             is_req;
    logic [7:0]       start_byte;
    logic             start_rs;
    logic [CFG_W-1:0] start_extra;

    wait_t            dur;
    wait_t            wait_inc;
    logic             is_boot;
    logic             jump;
    logic             do_finish;
    step_t            jump_step;

    // request decode
    always_comb
    begin
        is_req      = 1'b1;
        start_byte  = value;
        start_rs    = 1'b0;
        start_extra = '0;
        case (mode_t'(mode))
            MODE_CMD:   start_extra = CFG_W'(cfg.byte_settle_wait);
            MODE_CHAR:  start_rs = 1'b1;
            MODE_GOTO:  start_byte = BYTE_GOTO | {1'b0, value[6:0]};
            MODE_CLEAR:
            begin
                start_byte  = BYTE_CLEAR;
                start_extra = cfg.clear_wait;
            end
            default:    is_req = 1'b0;
        endcase

        req_step = step_reg;
        req_wait = wait_reg;
        req_held = held_reg;
        req_low  = low_nibble_reg;
        req_pend = pend_reg;
        req_sel  = sel_reg;
        req_nib  = nib_reg;
        req_en   = en_reg;
        req_rej  = 1'b0;
        if (is_req)
        begin
            if (step_reg != ST_IDLE)
            begin
                req_rej = 1'b1;
            end
            else
            begin
                req_held = start_byte;
                req_sel  = start_rs;
                req_low  = 1'b0;
                req_pend = start_extra;
                req_step = ST_U_STROBE;
                req_wait = '0;
                req_en   = 1'b1;
                req_nib  = start_byte[7:4];
            end
        end
    end

    // pin levels shown this tick
    always_comb
    begin
        result.reg_select  = req_sel;
        result.read_write  = 1'b0;
        result.data_nibble = req_nib;
        result.enable      = req_en;
        result.busy_res    = (req_step != ST_IDLE);
        result.rejected    = req_rej;
    end

    // step duration
    always_comb
    begin
        case (req_step)
            ST_POWER:                         dur = clip(cfg.power_on_wait);
            ST_I_STB1, ST_I_STB2, ST_I_STB3, ST_I_STB4,
            ST_U_STROBE, ST_B_STROBE:         dur = clip(CFG_W'(cfg.strobe_ticks));
            ST_I_WAIT1, ST_I_WAIT3:           dur = clip(cfg.long_init_wait);
            ST_I_WAIT2:                       dur = clip(cfg.short_init_wait);
            ST_I_WAIT4, ST_U_SETTLE, ST_B_SETTLE:
                                              dur = clip(CFG_W'(cfg.byte_settle_wait));
            ST_U_EXTRA, ST_B_EXTRA:           dur = clip(req_pend);
            default:                          dur = wait_t'(1);
        endcase
    end

    // next state
    always_comb
    begin
        step_next       = req_step;
        wait_next       = req_wait;
        held_next       = req_held;
        low_nibble_next = req_low;
        pend_next       = req_pend;
        sel_next        = req_sel;
        nib_next        = req_nib;
        en_next         = req_en;
        jump            = 1'b0;
        do_finish       = 1'b0;
        jump_step       = req_step;
        is_boot         = req_step inside {ST_B_STROBE, ST_B_GAP, ST_B_SETTLE, ST_B_EXTRA};
        wait_inc        = (req_wait < WAIT_MAX) ? req_wait + wait_t'(1) : req_wait;

        if (req_step != ST_IDLE)
        begin
            if (wait_inc < dur)
            begin
                wait_next = wait_inc;
            end
            else
            begin
                jump = 1'b1;
                case (req_step)
                    ST_POWER:   jump_step = ST_I_STB1;
                    ST_I_STB1:  jump_step = ST_I_WAIT1;
                    ST_I_WAIT1: jump_step = ST_I_STB2;
                    ST_I_STB2:  jump_step = ST_I_WAIT2;
                    ST_I_WAIT2: jump_step = ST_I_STB3;
                    ST_I_STB3:  jump_step = ST_I_WAIT3;
                    ST_I_WAIT3: jump_step = ST_I_STB4;
                    ST_I_STB4:  jump_step = ST_I_WAIT4;
                    ST_I_WAIT4:
                    begin
                        held_next       = BYTE_FUNC_SET;
                        sel_next        = 1'b0;
                        low_nibble_next = 1'b0;
                        pend_next       = '0;
                        jump_step       = ST_B_STROBE;
                    end
                    ST_U_STROBE, ST_B_STROBE:
                    begin
                        if (req_low)
                        begin
                            jump_step = is_boot ? ST_B_SETTLE : ST_U_SETTLE;
                        end
                        else
                        begin
                            jump_step = is_boot ? ST_B_GAP : ST_U_GAP;
                        end
                    end
                    ST_U_GAP, ST_B_GAP:
                    begin
                        low_nibble_next = 1'b1;
                        jump_step       = is_boot ? ST_B_STROBE : ST_U_STROBE;
                    end
                    ST_U_SETTLE, ST_B_SETTLE:
                    begin
                        if (req_pend != '0)
                        begin
                            jump_step = is_boot ? ST_B_EXTRA : ST_U_EXTRA;
                        end
                        else
                        begin
                            low_nibble_next = 1'b0;
                            do_finish       = 1'b1;
                        end
                    end
                    ST_U_EXTRA, ST_B_EXTRA:
                    begin
                        pend_next       = '0;
                        low_nibble_next = 1'b0;
                        do_finish       = 1'b1;
                    end
                    default:    jump_step = ST_IDLE;
                endcase

                // end of byte: chain the init bytes, else go idle
                if (do_finish)
                begin
                    jump_step = ST_IDLE;
                    if (is_boot)
                    begin
                        case (req_held)
                            BYTE_FUNC_SET:
                            begin
                                held_next = BYTE_DISP_ON;
                                pend_next = '0;
                                jump_step = ST_B_STROBE;
                            end
                            BYTE_DISP_ON:
                            begin
                                held_next = BYTE_ENTRY;
                                pend_next = '0;
                                jump_step = ST_B_STROBE;
                            end
                            BYTE_ENTRY:
                            begin
                                held_next = BYTE_CLEAR;
                                pend_next = cfg.clear_wait;
                                jump_step = ST_B_STROBE;
                            end
                            default:  jump_step = ST_IDLE;
                        endcase
                        if (jump_step == ST_B_STROBE)
                        begin
                            sel_next        = 1'b0;
                            low_nibble_next = 1'b0;
                        end
                    end
                end
            end
        end

        if (jump)
        begin
            step_next = jump_step;
            wait_next = '0;
            en_next   = 1'b0;
            if (jump_step inside {ST_I_STB1, ST_I_STB2, ST_I_STB3, ST_I_STB4})
            begin
                sel_next = 1'b0;
                nib_next = (jump_step == ST_I_STB4) ? NIB_4BIT : NIB_INIT;
                en_next  = 1'b1;
            end
            else if (jump_step == ST_U_STROBE || jump_step == ST_B_STROBE)
            begin
                nib_next = low_nibble_next ? held_next[3:0] : held_next[7:4];
                en_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= ST_POWER;
            wait_reg       <= '0;
            held_reg       <= '0;
            low_nibble_reg <= 1'b0;
            pend_reg       <= '0;
            sel_reg        <= 1'b0;
            nib_reg        <= '0;
            en_reg         <= 1'b0;
        end
        else if (accept)
        begin
            step_reg       <= step_next;
            wait_reg       <= wait_next;
            held_reg       <= held_next;
            low_nibble_reg <= low_nibble_next;
            pend_reg       <= pend_next;
            sel_reg        <= sel_next;
            nib_reg        <= nib_next;
            en_reg         <= en_next;
        end
    end

endmodule

`default_nettype wire

/* design/clni_skid.sv */
// ----------------------------------------------------------------------------
// clni_skid
// Result register with a spare stage; input stall comes from a register.
// ----------------------------------------------------------------------------
`default_nettype none

module clni_skid
    import clni_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  result_t   push_data,
    output logic      full,
    output logic      out_valid,
    input  wire logic out_stall,
    output result_t   out_data
);

    logic    main_valid_reg;
    logic    spare_valid_reg;
    result_t main_reg;
    result_t spare_reg;
    logic    pop;

    assign pop       = main_valid_reg & ~out_stall;
    assign full      = spare_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (spare_valid_reg)
            begin
                spare_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                spare_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (spare_valid_reg)
            begin
                main_reg <= spare_reg;
            end
            else if (push)
            begin
                main_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                spare_reg <= push_data;
            end
            else
            begin
                main_reg <= push_data;
            end
        end
    end

endmodule

`default_nettype wire

/* design/char_lcd_nibble_interface_top.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface_top
// HD44780-style character LCD driver on a 4-bit bus, one tick per transfer.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall   mode, value
//   out      source     out_valid / out_stall reg_select, read_write,
//                                             data_nibble, enable,
//                                             busy_res, rejected
//   cfg      sink       cfg_we                cfg_index, cfg_data
//
// One input transfer per clock while in_stall is low; each yields one registered result.
// The tick sequencer updates its step and tick counter together on each accepted transfer.
// Reset starts the power-on wait and init sequence; config resets to defaults.
// in_stall is high while both result stages hold data, after a push met a stalled out.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_interface_top
    import clni_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [2:0]           mode,
    input  wire logic [7:0]           value,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      reg_select,
    output logic                      read_write,
    output logic [3:0]                data_nibble,
    output logic                      enable,
    output logic                      busy_res,
    output logic                      rejected,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    cfg_t    cfg;
    result_t seq_result;
    result_t out_data;
    logic    accept;
    logic    full;

    assign in_stall = full;
    assign accept   = in_valid & ~full;

    clni_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    clni_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .mode   (mode),
        .value  (value),
        .cfg    (cfg),
        .result (seq_result)
    );

    clni_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (seq_result),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign reg_select  = out_data.reg_select;
    assign read_write  = out_data.read_write;
    assign data_nibble = out_data.data_nibble;
    assign enable      = out_data.enable;
    assign busy_res    = out_data.busy_res;
    assign rejected    = out_data.rejected;

endmodule

`default_nettype wire

/* design/clni_checker.sv */
// ----------------------------------------------------------------------------
// clni_checker
// Port-level checks on the LCD nibble interface, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_lcd_nibble_interface_top_assert.svh"

module clni_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       reg_select,
    input wire logic       read_write,
    input wire logic [3:0] data_nibble,
    input wire logic       enable,
    input wire logic       busy_res,
    input wire logic       rejected
);

    // enable pulses only happen inside a busy sequence
    `CLNI_ASSERT_IMPLY(a_enable_busy, out_valid && enable, busy_res, "enable high while idle")

    // a dropped request means the block was busy and stays busy
    `CLNI_ASSERT_IMPLY(a_reject_busy, out_valid && rejected, busy_res, "reject while idle")

    `CLNI_ASSERT_IMPLY(a_write_only, out_valid, !read_write, "read_write not low")

    // input stall only while a result is held
    `CLNI_ASSERT_IMPLY(a_stall_held, in_stall, out_valid, "input stalled with no result held")

    `CLNI_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable({reg_select, read_write, data_nibble, enable, busy_res, rejected}),
        "stalled result changed")

endmodule

bind char_lcd_nibble_interface_top clni_checker u_clni_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .reg_select  (reg_select),
    .read_write  (read_write),
    .data_nibble (data_nibble),
    .enable      (enable),
    .busy_res    (busy_res),
    .rejected    (rejected)
);

`default_nettype wire
